>>> design/primality_trial_division_6k_unit_assert.svh
// assertion macros shared by the primality unit modules
// both expect clk_i and rst_ni in the enclosing module
`ifndef PRIMALITY_TRIAL_DIVISION_6K_UNIT_ASSERT_SVH
`define PRIMALITY_TRIAL_DIVISION_6K_UNIT_ASSERT_SVH

// same-cycle implication
`define PTD6K_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define PTD6K_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/ptd6k_pkg.sv
package ptd6k_pkg;

  localparam int unsigned NUMBER_WIDTH_DEF   = 32;
  localparam int unsigned IN_WIDTH           = 32;
  localparam int unsigned CLASS_WIDTH        = 2;
  localparam int unsigned REM_BITS_PER_CYCLE = 4;

  typedef enum logic [CLASS_WIDTH-1:0] {
    CLASS_INVALID   = 2'd0,
    CLASS_UNIT      = 2'd1,
    CLASS_PRIME     = 2'd2,
    CLASS_COMPOSITE = 2'd3
  } class_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_sts_t;

endpackage

>>> design/ptd6k_rem.sv
`include "primality_trial_division_6k_unit_assert.svh"

module ptd6k_rem #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [WIDTH-1:0]    divisor_i,
  output ptd6k_pkg::rem_sts_t sts_o
);
  import ptd6k_pkg::*;

  localparam int unsigned Radix = REM_BITS_PER_CYCLE;
  localparam int unsigned PadW  = ((WIDTH + Radix - 1) / Radix) * Radix;
  localparam int unsigned Iter  = PadW / Radix;
  localparam int unsigned CntW  = $clog2(Iter + 1);

  logic            busy_q;
  logic            done_q;
  logic            zero_q;
  logic [CntW-1:0] cnt_q;
  logic [PadW-1:0] num_q, num_d;
  logic [WIDTH-1:0] div_q;
  logic [WIDTH-1:0] rem_q, rem_d;

  // radix-2 restoring steps, Radix bits per cycle
  always_comb begin
    logic [WIDTH:0]   trial;
    logic [WIDTH-1:0] acc;
    acc = rem_q;
    trial = '0;
    for (int i = 0; i < Radix; i++) begin
      trial = {acc, num_q[PadW-1-i]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      acc = trial[WIDTH-1:0];
    end
    rem_d = acc;
    num_d = num_q << Radix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Iter);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= PadW'(dividend_i);
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q  <= num_d;
      rem_q  <= rem_d;
      zero_q <= (rem_d == '0);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.zero = zero_q;

  `PTD6K_ASSERT_IMP(a_start_idle, start_i, !busy_q)
  `PTD6K_ASSERT_NXT(a_done_pulse, done_q, !done_q && !busy_q)
  `PTD6K_ASSERT_NXT(a_last_step_done, busy_q && cnt_q == CntW'(1), done_q)

endmodule

>>> design/primality_trial_division_6k_unit.sv
// invalid, one, two, three and even numbers are classified without the divider; otherwise the
// number is tested by three, then by each 6k-1/6k+1 pair d, d+2 while d^2 <= number, until the
// final bound check; all divisions share one remainder unit (4 quotient bits per cycle)
// one transaction at a time; input ready again once the result is registered
// asynchronous active-low reset clears the sequencer and the output valid
`include "primality_trial_division_6k_unit_assert.svh"

module primality_trial_division_6k_unit #(
  parameter int unsigned NUMBER_WIDTH = ptd6k_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ptd6k_pkg::IN_WIDTH-1:0]    number_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ptd6k_pkg::CLASS_WIDTH-1:0] class_code_o
);
  import ptd6k_pkg::*;

  localparam int unsigned SqW = NUMBER_WIDTH + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REM3,
    ST_BOUND,
    ST_REMA,
    ST_REMB,
    ST_DONE
  } state_e;

  state_e                  state_q;
  logic [NUMBER_WIDTH-1:0] num_ext;
  logic [NUMBER_WIDTH-1:0] v_q;
  logic [NUMBER_WIDTH-1:0] d_q;
  logic [SqW-1:0]          sq_q;
  logic [SqW-1:0]          sq_d;
  class_e                  cls_q;
  class_e                  out_cls_q;
  logic                    out_valid_q;
  logic                    rem_start_q;
  logic [NUMBER_WIDTH-1:0] rem_div_q;
  rem_sts_t                rem_sts;

  if (NUMBER_WIDTH <= IN_WIDTH) begin : g_trunc
    assign num_ext = number_i[NUMBER_WIDTH-1:0];
  end else begin : g_sext
    assign num_ext = {{(NUMBER_WIDTH - IN_WIDTH){number_i[IN_WIDTH-1]}}, number_i};
  end

  // (d+6)^2 = d^2 + 12d + 36
  assign sq_d = sq_q + (SqW'(d_q) << 3) + (SqW'(d_q) << 2) + SqW'(36);

  ptd6k_rem #(
    .WIDTH(NUMBER_WIDTH)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start_q),
    .dividend_i(v_q),
    .divisor_i (rem_div_q),
    .sts_o     (rem_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      rem_start_q <= 1'b0;
    end else begin
      rem_start_q <= 1'b0;
      if (out_valid_q && out_ready_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          priority if (v_q[NUMBER_WIDTH-1] || v_q == '0) begin
            cls_q   <= CLASS_INVALID;
            state_q <= ST_DONE;
          end else if (v_q == NUMBER_WIDTH'(1)) begin
            cls_q   <= CLASS_UNIT;
            state_q <= ST_DONE;
          end else if (v_q == NUMBER_WIDTH'(2) || v_q == NUMBER_WIDTH'(3)) begin
            cls_q   <= CLASS_PRIME;
            state_q <= ST_DONE;
          end else if (!v_q[0]) begin
            cls_q   <= CLASS_COMPOSITE;
            state_q <= ST_DONE;
          end else begin
            rem_start_q <= 1'b1;
            rem_div_q   <= NUMBER_WIDTH'(3);
            state_q     <= ST_REM3;
          end
        end
        ST_REM3: begin
          if (rem_sts.done) begin
            if (rem_sts.zero) begin
              cls_q   <= CLASS_COMPOSITE;
              state_q <= ST_DONE;
            end else begin
              d_q     <= NUMBER_WIDTH'(5);
              sq_q    <= SqW'(25);
              state_q <= ST_BOUND;
            end
          end
        end
        ST_BOUND: begin
          if (sq_q > SqW'(v_q)) begin
            cls_q   <= CLASS_PRIME;
            state_q <= ST_DONE;
          end else begin
            rem_start_q <= 1'b1;
            rem_div_q   <= d_q;
            state_q     <= ST_REMA;
          end
        end
        ST_REMA: begin
          if (rem_sts.done) begin
            if (rem_sts.zero) begin
              cls_q   <= CLASS_COMPOSITE;
              state_q <= ST_DONE;
            end else begin
              rem_start_q <= 1'b1;
              rem_div_q   <= d_q + NUMBER_WIDTH'(2);
              state_q     <= ST_REMB;
            end
          end
        end
        ST_REMB: begin
          if (rem_sts.done) begin
            if (rem_sts.zero) begin
              cls_q   <= CLASS_COMPOSITE;
              state_q <= ST_DONE;
            end else begin
              d_q     <= d_q + NUMBER_WIDTH'(6);
              sq_q    <= sq_d;
              state_q <= ST_BOUND;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_cls_q   <= cls_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      v_q <= num_ext;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign class_code_o = out_cls_q;

  `PTD6K_ASSERT_NXT(a_accept_check, in_valid_i && in_ready_o, state_q == ST_CHECK)
  `PTD6K_ASSERT_IMP(a_idle_rem_free, state_q == ST_IDLE, !rem_sts.busy && !rem_sts.done)
  `PTD6K_ASSERT_IMP(a_done_waiting, rem_sts.done,
                    state_q == ST_REM3 || state_q == ST_REMA || state_q == ST_REMB)
  `PTD6K_ASSERT_IMP(a_divisor_odd, state_q == ST_BOUND, d_q[0])

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ptd6k_pkg::*;

  class primality_scoreboard;
    class_e      expected_q[$];
    int unsigned mismatches;

    function class_e predict_class(input logic [31:0] raw, output int unsigned pairs);
      longint unsigned v;
      longint unsigned d;
      pairs = 0;
      v = raw;
      if (raw[31] || v == 0) return CLASS_INVALID;
      if (v == 1) return CLASS_UNIT;
      if (v > 3 && (v % 2 == 0 || v % 3 == 0)) return CLASS_COMPOSITE;
      for (d = 5; d <= v / d; d += 6) begin
        pairs++;
        if (v % d == 0 || v % (d + 2) == 0) return CLASS_COMPOSITE;
      end
      return CLASS_PRIME;
    endfunction

    function void note_number(input logic [31:0] raw);
      int unsigned pairs;
      expected_q.push_back(predict_class(raw, pairs));
    endfunction

    function void flag(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_class(input logic [1:0] actual);
      class_e want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result, actual %0d", actual));
        return;
      end
      want = expected_q.pop_front();
      if (actual !== want)
        flag($sformatf("class_code mismatch, expected %0d (%s) actual %0d",
                       want, want.name(), actual));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function bit clean();
      return mismatches == 0 && expected_q.size() == 0;
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid;
  logic                   in_ready_o;
  logic [IN_WIDTH-1:0]    number;
  logic                   out_valid_o;
  logic                   out_ready;
  logic [CLASS_WIDTH-1:0] class_code_o;

  primality_scoreboard sb = new();
  bit          quiet = 0;
  bit          hold_long = 0;
  int unsigned heavy_budget = 3;

  logic [31:0] directed_numbers [24] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
    32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169, 32'd997, 32'd1000003,
    32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
    32'h5555_5555, 32'hAAAA_AAAA
  };

  primality_trial_division_6k_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .number_i     (number),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .class_code_o (class_code_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) sb.note_number(number);
      if (out_valid_o && out_ready) sb.check_class(class_code_o);
    end
  end

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 15);
  endfunction

  // mostly cheap numbers; only a few may need the long divisor sweep
  function automatic logic [31:0] random_number();
    logic [31:0] n;
    int unsigned pairs;
    case ($urandom_range(0, 9))
      0, 1:    n = $urandom_range(0, 4095);
      2, 3:    n = $urandom_range(0, 32'h000F_FFFF);
      4:       n = ($urandom_range(2, 1023) | 1) * ($urandom_range(2, 1023) | 1);
      5:       begin
        n = $urandom();
        n[31] = 1'b1;
      end
      6:       n = 6 * $urandom_range(1, 5000) + ($urandom_range(0, 1) ? 1 : -1);
      7:       n = (32'd1 << $urandom_range(2, 20)) + $urandom_range(0, 6) - 3;
      default: begin
        n = $urandom();
        n[31] = 1'b0;
      end
    endcase
    void'(sb.predict_class(n, pairs));
    if (pairs > 400) begin
      if (heavy_budget == 0) n = n & 32'h000F_FFFF;
      else heavy_budget--;
    end
    return n;
  endfunction

  task automatic send_number(input logic [31:0] value, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    number   <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_long = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // sender side
  initial begin
    int i;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    number   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_numbers[j]) send_number(directed_numbers[j], pick_gap());

    // stall the output while the input keeps offering
    hold_long = 1;
    repeat (8) send_number($urandom_range(0, 255), 0);

    for (i = 0; i < 85; i++) begin
      if (i >= 70) quiet = 1;
      send_number(random_number(), pick_gap());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.clean()) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
